>>> hw/rtl/glyph_atlas_shelf_allocator_core_assert.svh
// assertion macros for the glyph atlas shelf allocator
// no dependencies; taken in by the checker
`ifndef GLYPH_ATLAS_SHELF_ALLOCATOR_CORE_ASSERT_SVH
`define GLYPH_ATLAS_SHELF_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define GASA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gasa assertion failed");

// next-cycle implication
`define GASA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gasa assertion failed");

`endif

>>> hw/rtl/gasa_pkg.sv
// shared types and constants of the glyph atlas shelf allocator
// no dependencies; used by the core and its checker
`timescale 1ns / 1ps

package gasa_pkg;

   // item field widths
   localparam int FUNC_W     = 2;
   localparam int DIM_W      = 11;
   localparam int STATUS_W   = 2;
   localparam int PAGE_W     = 3;
   localparam int POS_W      = 10;
   localparam int RECT_W     = 11;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_PAD_W  = RSP_DATA_W - (PAGE_W + 2 * POS_W + 4 * RECT_W);
   localparam int REQ_PAD_W  = REQ_DATA_W - 2 * DIM_W;

   // most results one flush gives
   localparam int RESULT_CAP = 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_FLUSH = 2'd1,
      FUNC_MARK  = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_NO_SPACE  = 2'd2,
      STATUS_NOT_DIRTY = 2'd3
   } status_type;

endpackage

>>> hw/rtl/gasa_alu.sv
// shared add and compare unit of the shelf allocator sequencer
// no dependencies; instanced once by the core
`timescale 1ns / 1ps

module gasa_alu #(
   parameter int W = 12
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic [W-1:0] c,
   input  logic         cin,
   output logic [W-1:0] sum,
   output logic         lt
);

   // sum with carry in, wraps at W bits (b all ones gives a - 1)
   assign sum = a + b + W'(cin);

   // unsigned compare of the sum against the bound
   assign lt = (sum < c);

endmodule

>>> hw/rtl/glyph_atlas_shelf_allocator_core.sv
// Allocate: size test, then page load and fit test on the current shelf, then a new shelf
// and further pages scanned or opened as needed, then dirty area, pen and shelf updates
// and the reply; too large replies after the size test, no space after the last page.
// Flush scans the pages in turn; mark-all steps through the pages in use. All arithmetic
// goes through the single shared add/compare unit stepped by the sequencer. One item at a
// time, the next taken once the sequencer is idle again; the last result may wait in the
// output register. Reset: synchronous, clears pens, shelves, dirty flags, one page in use.
`timescale 1ns / 1ps

module glyph_atlas_shelf_allocator_core #(
   parameter int ATLAS_SIZE = 1024,
   parameter int MAX_PAGES  = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // request items
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [gasa_pkg::REQ_DATA_W-1:0] req_tdata,  // glyph_width, glyph_height, pad
   input  logic [gasa_pkg::FUNC_W-1:0]    req_tuser,   // func
   // result items
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [gasa_pkg::RSP_DATA_W-1:0] rsp_tdata,  // page, pos_x, pos_y, rect_left,
                                                       // rect_top, rect_right,
                                                       // rect_bottom, pad
   output logic [gasa_pkg::STATUS_W-1:0]  rsp_tuser,   // status
   output logic                           rsp_tlast
);

   import gasa_pkg::*;

   // coordinate widths: stored values reach twice the page size, sums also hold a glyph
   localparam int CW    = $clog2(ATLAS_SIZE + 1) + 1;
   localparam int SW    = (CW > DIM_W + 1) ? CW : DIM_W + 1;
   localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int PIU_W = $clog2(MAX_PAGES + 1);
   localparam int CNT_W = $clog2(RESULT_CAP);

   localparam logic [SW-1:0]    LIM      = SW'(ATLAS_SIZE - 1);
   localparam logic [SW-1:0]    ONE      = SW'(1);
   localparam logic [SW-1:0]    ALL_ONES = '1;
   localparam logic [CW-1:0]    FULL_W   = CW'(ATLAS_SIZE);
   localparam logic [PIU_W-1:0] PAGES    = PIU_W'(MAX_PAGES);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RESULT_CAP - 1);

   typedef enum logic [4:0] {
      S_IDLE,
      S_SIZE_W,
      S_SIZE_H,
      S_PG_LOAD,
      S_FIT_X,
      S_FIT_Y,
      S_NY,
      S_NFIT_X,
      S_NFIT_Y,
      S_UPD_R,
      S_UPD_B,
      S_UPD_SB,
      S_UPD_L,
      S_UPD_T,
      S_REPLY,
      S_FL_START,
      S_FL_SCAN,
      S_MARK
   } state_type;

   state_type        state_ff;
   logic [SW-1:0]    w_ff, h_ff, cx_ff, cy_ff, ny_ff;
   logic             fx_ff;
   logic [PW-1:0]    page_ff;
   logic [PIU_W-1:0] piu_ff;
   logic [CNT_W-1:0] cnt_ff;
   status_type       st_ff;

   // per-page state
   logic [CW-1:0]        pen_col_ff   [MAX_PAGES];
   logic [CW-1:0]        pen_row_ff   [MAX_PAGES];
   logic [CW-1:0]        shelf_ff     [MAX_PAGES];
   logic [CW-1:0]        dirty_l_ff   [MAX_PAGES];
   logic [CW-1:0]        dirty_t_ff   [MAX_PAGES];
   logic [CW-1:0]        dirty_r_ff   [MAX_PAGES];
   logic [CW-1:0]        dirty_b_ff   [MAX_PAGES];
   logic [MAX_PAGES-1:0] dirty_v_ff;

   // result register
   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   status_type            rsp_tuser_ff;
   logic                  rsp_tlast_ff;

   logic [SW-1:0]    pc_cur, pr_cur, sb_cur, dl_cur, dt_cur, dr_cur, db_cur;
   logic             dv_cur;
   logic [SW-1:0]    alu_a, alu_b, alu_c, alu_sum;
   logic             alu_cin, alu_lt;
   logic [PIU_W-1:0] page_nx_in;
   logic             later_in;
   logic             out_free;
   logic             rsp_load;
   logic             fl_last_in;

   // current page entries, widened to arithmetic width
   assign pc_cur = SW'(pen_col_ff[page_ff]);
   assign pr_cur = SW'(pen_row_ff[page_ff]);
   assign sb_cur = SW'(shelf_ff[page_ff]);
   assign dl_cur = SW'(dirty_l_ff[page_ff]);
   assign dt_cur = SW'(dirty_t_ff[page_ff]);
   assign dr_cur = SW'(dirty_r_ff[page_ff]);
   assign db_cur = SW'(dirty_b_ff[page_ff]);
   assign dv_cur = dirty_v_ff[page_ff];

   assign page_nx_in = PIU_W'(page_ff) + PIU_W'(1);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // result register takes a new item this cycle
   assign rsp_load = out_free &&
                     ((state_ff == S_REPLY) || ((state_ff == S_FL_SCAN) && dv_cur));

   // any dirty page after the current one
   always_comb begin
      later_in = 1'b0;
      for (int i = 0; i < MAX_PAGES; i++) begin
         if ((PW'(i) > page_ff) && dirty_v_ff[i]) begin
            later_in = 1'b1;
         end
      end
   end

   assign fl_last_in = (cnt_ff == CNT_LAST) || !later_in;

   // operand selection for the shared unit
   always_comb begin
      alu_a   = cx_ff;
      alu_b   = w_ff;
      alu_c   = LIM;
      alu_cin = 1'b0;
      case (state_ff)
         S_SIZE_W: begin
            alu_a = w_ff;
            alu_b = '0;
         end
         S_SIZE_H: begin
            alu_a = h_ff;
            alu_b = '0;
         end
         S_FIT_Y: begin
            alu_a = cy_ff;
            alu_b = h_ff;
         end
         S_NY: begin
            alu_a   = sb_cur;
            alu_b   = '0;
            alu_cin = 1'b1;
            alu_c   = cy_ff;
         end
         S_NFIT_X: begin
            alu_a = ONE;
         end
         S_NFIT_Y: begin
            alu_a = ny_ff;
            alu_b = h_ff;
         end
         S_UPD_R: begin
            alu_cin = 1'b1;
            alu_c   = dr_cur;
         end
         S_UPD_B: begin
            alu_a   = cy_ff;
            alu_b   = h_ff;
            alu_cin = 1'b1;
            alu_c   = db_cur;
         end
         S_UPD_SB: begin
            alu_a = cy_ff;
            alu_b = h_ff;
            alu_c = sb_cur;
         end
         S_UPD_L: begin
            alu_b = ALL_ONES;
            alu_c = dl_cur;
         end
         S_UPD_T: begin
            alu_a = cy_ff;
            alu_b = ALL_ONES;
            alu_c = dt_cur;
         end
         S_MARK: begin
            alu_a   = sb_cur;
            alu_b   = '0;
            alu_cin = 1'b1;
         end
         default: begin
            alu_a = cx_ff;
         end
      endcase
   end

   gasa_alu #(
      .W (SW)
   ) u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .c   (alu_c),
      .cin (alu_cin),
      .sum (alu_sum),
      .lt  (alu_lt)
   );

   // sequencer, page state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         piu_ff        <= PIU_W'(1);
         page_ff       <= '0;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
         dirty_v_ff    <= '0;
         for (int i = 0; i < MAX_PAGES; i++) begin
            pen_col_ff[i] <= '0;
            pen_row_ff[i] <= '0;
            shelf_ff[i]   <= '0;
         end
      end else begin
         if (rsp_tvalid_ff && rsp_tready && !rsp_load) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  w_ff    <= SW'(req_tdata[DIM_W-1:0]);
                  h_ff    <= SW'(req_tdata[2*DIM_W-1:DIM_W]);
                  page_ff <= '0;
                  cnt_ff  <= '0;
                  case (func_type'(req_tuser))
                     FUNC_ALLOC: state_ff <= S_SIZE_W;
                     FUNC_FLUSH: state_ff <= S_FL_START;
                     FUNC_MARK:  state_ff <= S_MARK;
                     default:    state_ff <= S_IDLE;
                  endcase
               end
            end
            // size test: each side below page size minus one
            S_SIZE_W: begin
               fx_ff    <= alu_lt;
               state_ff <= S_SIZE_H;
            end
            S_SIZE_H: begin
               if (fx_ff && alu_lt) begin
                  state_ff <= S_PG_LOAD;
               end else begin
                  st_ff    <= STATUS_TOO_LARGE;
                  state_ff <= S_REPLY;
               end
            end
            // fresh page pen starts at one, one
            S_PG_LOAD: begin
               if (pc_cur == '0 || pr_cur == '0) begin
                  pen_col_ff[page_ff] <= CW'(1);
                  pen_row_ff[page_ff] <= CW'(1);
                  cx_ff <= ONE;
                  cy_ff <= ONE;
               end else begin
                  cx_ff <= pc_cur;
                  cy_ff <= pr_cur;
               end
               state_ff <= S_FIT_X;
            end
            S_FIT_X: begin
               fx_ff    <= alu_lt;
               state_ff <= S_FIT_Y;
            end
            S_FIT_Y: begin
               state_ff <= (fx_ff && alu_lt) ? S_UPD_R : S_NY;
            end
            // new shelf row: max of pen row and shelf bottom plus one
            S_NY: begin
               ny_ff    <= alu_lt ? cy_ff : alu_sum;
               state_ff <= S_NFIT_X;
            end
            S_NFIT_X: begin
               fx_ff    <= alu_lt;
               state_ff <= S_NFIT_Y;
            end
            S_NFIT_Y: begin
               if (fx_ff && alu_lt) begin
                  pen_col_ff[page_ff] <= CW'(1);
                  pen_row_ff[page_ff] <= CW'(ny_ff);
                  cx_ff    <= ONE;
                  cy_ff    <= ny_ff;
                  state_ff <= S_UPD_R;
               end else if (page_nx_in < piu_ff) begin
                  page_ff  <= PW'(page_nx_in);
                  state_ff <= S_PG_LOAD;
               end else if (piu_ff < PAGES) begin
                  // open the next page; it still holds its reset values
                  piu_ff   <= piu_ff + PIU_W'(1);
                  page_ff  <= PW'(page_nx_in);
                  state_ff <= S_PG_LOAD;
               end else begin
                  st_ff    <= STATUS_NO_SPACE;
                  state_ff <= S_REPLY;
               end
            end
            // placement: grow dirty area, advance pen, lower shelf
            S_UPD_R: begin
               dirty_r_ff[page_ff] <= (dv_cur && alu_lt) ? CW'(dr_cur) : CW'(alu_sum);
               pen_col_ff[page_ff] <= CW'(alu_sum);
               state_ff <= S_UPD_B;
            end
            S_UPD_B: begin
               dirty_b_ff[page_ff] <= (dv_cur && alu_lt) ? CW'(db_cur) : CW'(alu_sum);
               state_ff <= S_UPD_SB;
            end
            S_UPD_SB: begin
               shelf_ff[page_ff] <= alu_lt ? CW'(sb_cur) : CW'(alu_sum);
               state_ff <= S_UPD_L;
            end
            S_UPD_L: begin
               dirty_l_ff[page_ff] <= (dv_cur && !alu_lt) ? CW'(dl_cur) : CW'(alu_sum);
               state_ff <= S_UPD_T;
            end
            S_UPD_T: begin
               dirty_t_ff[page_ff] <= (dv_cur && !alu_lt) ? CW'(dt_cur) : CW'(alu_sum);
               dirty_v_ff[page_ff] <= 1'b1;
               st_ff    <= STATUS_OK;
               state_ff <= S_REPLY;
            end
            // single result of an allocate or an empty flush
            S_REPLY: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tuser_ff  <= st_ff;
                  rsp_tlast_ff  <= 1'b1;
                  if (st_ff == STATUS_OK) begin
                     rsp_tdata_ff <= {{RSP_PAD_W{1'b0}}, {(4 * RECT_W){1'b0}},
                                      cy_ff[POS_W-1:0], cx_ff[POS_W-1:0],
                                      PAGE_W'(page_ff)};
                  end else begin
                     rsp_tdata_ff <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_FL_START: begin
               if (dirty_v_ff == '0) begin
                  st_ff    <= STATUS_NOT_DIRTY;
                  state_ff <= S_REPLY;
               end else begin
                  state_ff <= S_FL_SCAN;
               end
            end
            // one page a cycle, a dirty page waits for the result register
            S_FL_SCAN: begin
               if (!dv_cur) begin
                  page_ff <= PW'(page_nx_in);
               end else if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tuser_ff  <= STATUS_OK;
                  rsp_tlast_ff  <= fl_last_in;
                  rsp_tdata_ff  <= {{RSP_PAD_W{1'b0}},
                                    db_cur[RECT_W-1:0], dr_cur[RECT_W-1:0],
                                    dt_cur[RECT_W-1:0], dl_cur[RECT_W-1:0],
                                    {(2 * POS_W){1'b0}}, PAGE_W'(page_ff)};
                  dirty_v_ff[page_ff] <= 1'b0;
                  dirty_l_ff[page_ff] <= '0;
                  dirty_t_ff[page_ff] <= '0;
                  dirty_r_ff[page_ff] <= '0;
                  dirty_b_ff[page_ff] <= '0;
                  cnt_ff <= cnt_ff + CNT_W'(1);
                  if (fl_last_in) begin
                     state_ff <= S_IDLE;
                  end else begin
                     page_ff <= PW'(page_nx_in);
                  end
               end
            end
            // whole page dirty down to its shelf
            S_MARK: begin
               dirty_v_ff[page_ff] <= 1'b1;
               dirty_l_ff[page_ff] <= '0;
               dirty_t_ff[page_ff] <= '0;
               dirty_r_ff[page_ff] <= FULL_W;
               dirty_b_ff[page_ff] <= CW'(alu_sum);
               if (page_nx_in < piu_ff) begin
                  page_ff <= PW'(page_nx_in);
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

>>> hw/rtl/gasa_checker.sv
// port-level checks of the glyph atlas shelf allocator core
// depends on gasa_pkg and the assertion macro header; bound to the core
`timescale 1ns / 1ps
`include "glyph_atlas_shelf_allocator_core_assert.svh"

module gasa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gasa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [gasa_pkg::STATUS_W-1:0]   rsp_tuser,
   input logic                            rsp_tlast
);

   import gasa_pkg::*;

   localparam int POS_LO  = PAGE_W;
   localparam int RECT_LO = PAGE_W + 2 * POS_W;

   logic rsp_stall;
   logic rsp_err;
   logic rsp_ok;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_err   = rsp_tvalid && (rsp_tuser != STATUS_OK);
   assign rsp_ok    = rsp_tvalid && (rsp_tuser == STATUS_OK);

   // a stalled item stays and holds
   `GASA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid)
   `GASA_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall,
                     $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // every failure or empty flush is a lone, final item with no payload
   `GASA_ASSERT_NOW(a_err_last, clock, reset, rsp_err, rsp_tlast)
   `GASA_ASSERT_NOW(a_err_zero, clock, reset, rsp_err, rsp_tdata == '0)

   // a placement carries no rectangle, a flushed rectangle no position
   `GASA_ASSERT_NOW(a_ok_kind, clock, reset, rsp_ok,
                    (rsp_tdata[POS_LO +: 2 * POS_W] == '0) ||
                    (rsp_tdata[RECT_LO +: 4 * RECT_W] == '0))

endmodule

bind glyph_atlas_shelf_allocator_core gasa_checker u_gasa_checker (.*);

>>> tb/sv/glyph_atlas_shelf_allocator_core_tb.sv
// self-checking testbench for the glyph atlas shelf allocator core
// depends on gasa_pkg and glyph_atlas_shelf_allocator_core; stream driver and monitor
// with a built-in shelf packing predictor and random idling on both sides
`timescale 1ns / 1ps

module glyph_atlas_shelf_allocator_core_tb;
   import gasa_pkg::*;

   localparam int ATLAS      = 1024;
   localparam int PAGES      = 8;
   localparam int CLK_PERIOD = 10;

   // unused request code, ignored by the block
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // result tdata layout, lowest field first
   localparam int POS_X_LSB  = PAGE_W;
   localparam int POS_Y_LSB  = POS_X_LSB + POS_W;
   localparam int LEFT_LSB   = POS_Y_LSB + POS_W;
   localparam int TOP_LSB    = LEFT_LSB + RECT_W;
   localparam int RIGHT_LSB  = TOP_LSB + RECT_W;
   localparam int BOTTOM_LSB = RIGHT_LSB + RECT_W;

   localparam int RANDOM_ITEMS   = 480;
   localparam int HOLD_AT        = 150;
   localparam int HOLD_LEN       = 400;
   localparam int SETTLE_CYCLES  = 100;
   localparam int TIMEOUT_CYCLES = 1500000;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [DIM_W-1:0]  glyph_width;
      logic [DIM_W-1:0]  glyph_height;
      bit                drain_first;
   } glyph_request_type;

   typedef struct packed {
      status_type          status;
      logic [PAGE_W-1:0]   page;
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic [RECT_W-1:0]   rect_left;
      logic [RECT_W-1:0]   rect_top;
      logic [RECT_W-1:0]   rect_right;
      logic [RECT_W-1:0]   rect_bottom;
      logic                last;
   } atlas_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;

   glyph_atlas_shelf_allocator_core #(
      .ATLAS_SIZE (ATLAS),
      .MAX_PAGES  (PAGES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // glyph_width, glyph_height, pad
      .req_tuser  (req_tuser),   // func
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // page, pos_x, pos_y, rect_left, rect_top,
                                 // rect_right, rect_bottom, pad
      .rsp_tuser  (rsp_tuser),   // status
      .rsp_tlast  (rsp_tlast)
   );

   // predictor copy of the atlas state
   int unsigned cursor_x   [PAGES];
   int unsigned cursor_y   [PAGES];
   int unsigned shelf_floor[PAGES];
   bit          dirty_on   [PAGES];
   int unsigned dirty_x0   [PAGES];
   int unsigned dirty_y0   [PAGES];
   int unsigned dirty_x1   [PAGES];
   int unsigned dirty_y1   [PAGES];
   int unsigned open_pages = 1;

   glyph_request_type request_queue[$];
   atlas_result_type  awaited_results[$];
   glyph_request_type req_now;
   bit                req_taken = 1'b0;

   int send_gap     = 0;
   int ready_gap    = 0;
   int hold_cycles  = 0;
   bit hold_done    = 1'b0;
   int calm_cycles  = 0;

   int fail_count     = 0;
   int accepted_items = 0;
   int results_seen   = 0;
   int placed_count   = 0;
   int too_large_count = 0;
   int no_space_count = 0;
   int rect_count     = 0;
   int clean_count    = 0;
   int mark_count     = 0;

   function automatic bit glyph_fits(int unsigned x, int unsigned y,
                                     int unsigned w, int unsigned h);
      return (x + w < ATLAS - 1) && (y + h < ATLAS - 1);
   endfunction

   // idle length: mostly short, now and then long
   function automatic int idle_span();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      else if (roll < 95) return $urandom_range(4, 15);
      else return $urandom_range(30, 80);
   endfunction

   // glyph sizes at the boundaries of the page
   function automatic int unsigned border_dim();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 1;
         2: return ATLAS - 3;
         default: return ATLAS - 2;
      endcase
   endfunction

   task automatic await_result(status_type st, int unsigned page, int unsigned px,
                               int unsigned py, int unsigned l, int unsigned t,
                               int unsigned r, int unsigned b, bit last);
      atlas_result_type res;
      res.status      = st;
      res.page        = page[PAGE_W-1:0];
      res.pos_x       = px[POS_W-1:0];
      res.pos_y       = py[POS_W-1:0];
      res.rect_left   = l[RECT_W-1:0];
      res.rect_top    = t[RECT_W-1:0];
      res.rect_right  = r[RECT_W-1:0];
      res.rect_bottom = b[RECT_W-1:0];
      res.last        = last;
      awaited_results.push_back(res);
   endtask

   // work out the results of one accepted request and update the atlas copy
   task automatic predict_atlas_request(glyph_request_type rq);
      int          placed;
      int          dirty_count;
      int          n;
      bit          full;
      int unsigned w, h, x, y, new_row;
      w = rq.glyph_width;
      h = rq.glyph_height;
      case (rq.func)
         FUNC_ALLOC: begin
            if (w > ATLAS - 2 || h > ATLAS - 2) begin
               await_result(STATUS_TOO_LARGE, 0, 0, 0, 0, 0, 0, 0, 1'b1);
               too_large_count++;
            end else begin
               placed = -1;
               full   = 1'b0;
               while (placed < 0 && !full) begin
                  // current shelf first, then a fresh shelf below it
                  for (int p = 0; p < open_pages && placed < 0; p++) begin
                     if (cursor_x[p] == 0 || cursor_y[p] == 0) begin
                        cursor_x[p] = 1;
                        cursor_y[p] = 1;
                     end
                     if (glyph_fits(cursor_x[p], cursor_y[p], w, h)) begin
                        placed = p;
                     end else begin
                        new_row = (cursor_y[p] > shelf_floor[p] + 1) ?
                                  cursor_y[p] : shelf_floor[p] + 1;
                        if (glyph_fits(1, new_row, w, h)) begin
                           cursor_x[p] = 1;
                           cursor_y[p] = new_row;
                           placed = p;
                        end
                     end
                  end
                  // nothing fits: open another page if one is left
                  if (placed < 0) begin
                     if (open_pages >= PAGES) begin
                        full = 1'b1;
                     end else begin
                        cursor_x[open_pages]    = 0;
                        cursor_y[open_pages]    = 0;
                        shelf_floor[open_pages] = 0;
                        dirty_on[open_pages]    = 1'b0;
                        dirty_x0[open_pages]    = 0;
                        dirty_y0[open_pages]    = 0;
                        dirty_x1[open_pages]    = 0;
                        dirty_y1[open_pages]    = 0;
                        open_pages++;
                     end
                  end
               end
               if (placed < 0) begin
                  await_result(STATUS_NO_SPACE, 0, 0, 0, 0, 0, 0, 0, 1'b1);
                  no_space_count++;
               end else begin
                  x = cursor_x[placed];
                  y = cursor_y[placed];
                  // grow the dirty area by the gutter around the glyph
                  if (!dirty_on[placed]) begin
                     dirty_on[placed] = 1'b1;
                     dirty_x0[placed] = x - 1;
                     dirty_y0[placed] = y - 1;
                     dirty_x1[placed] = x + w + 1;
                     dirty_y1[placed] = y + h + 1;
                  end else begin
                     if (x - 1 < dirty_x0[placed]) dirty_x0[placed] = x - 1;
                     if (y - 1 < dirty_y0[placed]) dirty_y0[placed] = y - 1;
                     if (x + w + 1 > dirty_x1[placed]) dirty_x1[placed] = x + w + 1;
                     if (y + h + 1 > dirty_y1[placed]) dirty_y1[placed] = y + h + 1;
                  end
                  cursor_x[placed] = x + w + 1;
                  if (y + h > shelf_floor[placed]) shelf_floor[placed] = y + h;
                  await_result(STATUS_OK, placed, x, y, 0, 0, 0, 0, 1'b1);
                  placed_count++;
               end
            end
         end
         FUNC_FLUSH: begin
            dirty_count = 0;
            for (int p = 0; p < PAGES; p++) begin
               if (dirty_on[p] && dirty_count < RESULT_CAP) dirty_count++;
            end
            if (dirty_count == 0) begin
               await_result(STATUS_NOT_DIRTY, 0, 0, 0, 0, 0, 0, 0, 1'b1);
               clean_count++;
            end else begin
               n = 0;
               for (int p = 0; p < PAGES && n < dirty_count; p++) begin
                  if (dirty_on[p]) begin
                     n++;
                     await_result(STATUS_OK, p, 0, 0, dirty_x0[p], dirty_y0[p],
                                  dirty_x1[p], dirty_y1[p], n == dirty_count);
                     dirty_on[p] = 1'b0;
                     dirty_x0[p] = 0;
                     dirty_y0[p] = 0;
                     dirty_x1[p] = 0;
                     dirty_y1[p] = 0;
                  end
               end
               rect_count += dirty_count;
            end
         end
         FUNC_MARK: begin
            for (int p = 0; p < open_pages; p++) begin
               dirty_on[p] = 1'b1;
               dirty_x0[p] = 0;
               dirty_y0[p] = 0;
               dirty_x1[p] = ATLAS;
               dirty_y1[p] = shelf_floor[p] + 1;
            end
            mark_count++;
         end
         default: ;
      endcase
   endtask

   task automatic check_field(string field_name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field_name, want, got);
         fail_count++;
      end
   endtask

   task automatic add_request(logic [FUNC_W-1:0] func, int unsigned w, int unsigned h,
                              bit drain);
      glyph_request_type rq;
      rq.func         = func;
      rq.glyph_width  = w[DIM_W-1:0];
      rq.glyph_height = h[DIM_W-1:0];
      rq.drain_first  = drain;
      request_queue.push_back(rq);
   endtask

   // boundaries, every request kind and the awkward cases
   task automatic queue_directed_requests();
      add_request(FUNC_FLUSH, 0, 0, 1'b0);               // flush with nothing dirty
      add_request(FUNC_MARK, ATLAS, ATLAS, 1'b0);        // mark with an empty shelf
      add_request(FUNC_FLUSH, ATLAS, ATLAS, 1'b0);
      add_request(FUNC_ALLOC, 0, 0, 1'b0);               // zero-sized glyph on a fresh page
      add_request(FUNC_ALLOC, ATLAS - 1, 5, 1'b0);       // too wide
      add_request(FUNC_ALLOC, 5, ATLAS, 1'b0);           // too tall
      add_request(FUNC_ALLOC, ATLAS, ATLAS, 1'b0);
      add_request(FUNC_ALLOC, ATLAS - 3, 10, 1'b0);      // needs a new shelf
      add_request(FUNC_ALLOC, 10, ATLAS - 3, 1'b0);      // needs a second page
      add_request(FUNC_UNUSED, ATLAS - 1, ATLAS, 1'b0);  // ignored code
      add_request(FUNC_FLUSH, 0, 0, 1'b0);
      add_request(FUNC_ALLOC, ATLAS - 2, 3, 1'b0);       // opens every page, then full
      add_request(FUNC_ALLOC, 3, ATLAS - 2, 1'b0);
      add_request(FUNC_MARK, 0, 0, 1'b0);
      add_request(FUNC_FLUSH, 0, 0, 1'b0);               // one rectangle per page
      add_request(FUNC_FLUSH, 0, 0, 1'b0);
      add_request(FUNC_ALLOC, 1, 1, 1'b0);
      add_request(FUNC_ALLOC, 682, 341, 1'b0);
      add_request(FUNC_ALLOC, 341, 682, 1'b0);
      add_request(FUNC_ALLOC, 1, ATLAS - 3, 1'b0);
      add_request(FUNC_MARK, 0, 0, 1'b1);                // sender waits for the backlog
      add_request(FUNC_FLUSH, 0, 0, 1'b0);
      add_request(FUNC_UNUSED, 0, 0, 1'b0);
   endtask

   // mostly allocations across a spread of glyph sizes, some flushes and marks
   task automatic queue_random_requests(int count);
      int                made, roll, dim_roll;
      logic [FUNC_W-1:0] func_code;
      int unsigned       w, h;
      made = 0;
      while (made < count) begin
         roll     = $urandom_range(0, 99);
         dim_roll = $urandom_range(0, 99);
         if (dim_roll < 50) begin
            w = $urandom_range(1, 48);
            h = $urandom_range(1, 48);
         end else if (dim_roll < 75) begin
            w = $urandom_range(49, 300);
            h = $urandom_range(49, 300);
         end else if (dim_roll < 87) begin
            w = $urandom_range(301, ATLAS - 2);
            h = $urandom_range(301, ATLAS - 2);
         end else if (dim_roll < 93) begin
            w = border_dim();
            h = border_dim();
         end else if ($urandom_range(0, 1) == 0) begin
            w = $urandom_range(ATLAS - 1, ATLAS);
            h = $urandom_range(0, ATLAS);
         end else begin
            w = $urandom_range(0, ATLAS);
            h = $urandom_range(ATLAS - 1, ATLAS);
         end
         if (roll < 78) func_code = FUNC_ALLOC;
         else if (roll < 90) func_code = FUNC_FLUSH;
         else if (roll < 97) func_code = FUNC_MARK;
         else func_code = FUNC_UNUSED;
         add_request(func_code, w, h, (made % 120) == 0 && func_code != FUNC_UNUSED);
         if (func_code != FUNC_UNUSED) made++;
      end
   endtask

   // clock
   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // request driver: holds an item until taken, then idles or offers the next
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (request_queue.size() != 0 &&
                      !(request_queue[0].drain_first && awaited_results.size() != 0)) begin
            req_now = request_queue.pop_front();
            req_tdata  <= {{REQ_PAD_W{1'b0}}, req_now.glyph_height, req_now.glyph_width};
            req_tuser  <= req_now.func;
            req_tvalid <= 1'b1;
            send_gap = (calm_cycles > 0 || $urandom_range(0, 99) >= 35) ? 0 : idle_span();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver readiness
   always @(negedge clock) begin
      if (reset || hold_cycles > 0) begin
         rsp_tready <= 1'b0;
      end else if (ready_gap > 0) begin
         ready_gap--;
         rsp_tready <= 1'b0;
      end else if (calm_cycles == 0 && $urandom_range(0, 99) < 20) begin
         ready_gap = idle_span() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // long receiver hold-off once, and stretches with no idling on either side
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_cycles > 0) begin
            hold_cycles--;
         end else if (!hold_done && accepted_items >= HOLD_AT) begin
            hold_cycles = HOLD_LEN;
            hold_done   = 1'b1;
         end
         if (calm_cycles > 0) calm_cycles--;
         else if ($urandom_range(0, 999) < 4) calm_cycles = $urandom_range(40, 160);
      end
   end

   // monitor: check each result item, then predict from each accepted request
   always @(posedge clock) begin
      atlas_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               $error("result item with none outstanding: status %0d tdata %h",
                      rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("status", want.status, rsp_tuser);
               check_field("page", want.page, rsp_tdata[0 +: PAGE_W]);
               check_field("pos_x", want.pos_x, rsp_tdata[POS_X_LSB +: POS_W]);
               check_field("pos_y", want.pos_y, rsp_tdata[POS_Y_LSB +: POS_W]);
               check_field("rect_left", want.rect_left, rsp_tdata[LEFT_LSB +: RECT_W]);
               check_field("rect_top", want.rect_top, rsp_tdata[TOP_LSB +: RECT_W]);
               check_field("rect_right", want.rect_right, rsp_tdata[RIGHT_LSB +: RECT_W]);
               check_field("rect_bottom", want.rect_bottom,
                           rsp_tdata[BOTTOM_LSB +: RECT_W]);
               check_field("last", want.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_atlas_request(req_now);
            req_taken = 1'b1;
            accepted_items++;
         end
      end
   end

   // run limit
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("timeout with %0d result items outstanding", awaited_results.size());
      $display("glyph_atlas_shelf_allocator_core_tb failed");
      $finish;
   end

   // sequence: reset, stimulus, drain, verdict
   initial begin
      queue_directed_requests();
      queue_random_requests(RANDOM_ITEMS);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (request_queue.size() != 0 || req_tvalid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $error("%0d result items never arrived", awaited_results.size());
         fail_count++;
      end
      $display("%0d requests taken: %0d glyphs placed, %0d too large, %0d atlas full",
               accepted_items, placed_count, too_large_count, no_space_count);
      $display("%0d dirty rectangles flushed, %0d clean flushes, %0d mark-all, %0d results",
               rect_count, clean_count, mark_count, results_seen);
      if (fail_count == 0) begin
         $display("glyph_atlas_shelf_allocator_core_tb passed");
      end else begin
         $display("glyph_atlas_shelf_allocator_core_tb failed");
      end
      $finish;
   end

endmodule
